// File: rtl/minimum_spanning_tree_kruskal_defines.svh
// Assertion macros for the spanning tree block checker.
`ifndef MINIMUM_SPANNING_TREE_KRUSKAL_DEFINES_SVH
`define MINIMUM_SPANNING_TREE_KRUSKAL_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define MSTK_CHK_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mstk port check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define MSTK_CHK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mstk port check failed");

`endif

// File: rtl/mstk_pkg.sv
// Shared types and constants for the spanning tree block.
`timescale 1ns / 1ps
package mstk_pkg;
  localparam int MAX_VERTICES = 64;
  localparam int MAX_EDGES    = 256;
  localparam int WEIGHT_BITS  = 16;
  localparam int VW = $clog2(MAX_VERTICES);   // vertex id bits
  localparam int CFGW = VW + 1;               // vertex count bits
  localparam int EW = $clog2(MAX_EDGES);      // edge address bits
  localparam int CW = EW + 1;                 // edge count bits
  localparam int KW = WEIGHT_BITS + EW;       // sort key bits

  typedef struct packed {
    logic [VW-1:0]                 src;
    logic [VW-1:0]                 dest;
    logic signed [WEIGHT_BITS-1:0] weight;
  } edge_t;

  typedef struct packed {
    logic store;
    logic init;
    logic scan;
    logic look;
    logic cmp;
    logic merge;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic init_done;
    logic scan_done;
    logic found;
    logic take;
    logic merge_done;
    logic emit_done;
  } sts_t;
endpackage

// File: rtl/mstk_ctrl.sv
// Phase sequencer for load, label init, sort scan, union and emit.
`timescale 1ns / 1ps
module mstk_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic           last_edge,
  input  mstk_pkg::sts_t sts,
  output mstk_pkg::cmd_t cmd,
  output logic           busy
);
  typedef enum logic [6:0] {
    S_LOAD  = 7'b0000001,
    S_INIT  = 7'b0000010,
    S_SCAN  = 7'b0000100,
    S_LOOK  = 7'b0001000,
    S_CMP   = 7'b0010000,
    S_MERGE = 7'b0100000,
    S_EMIT  = 7'b1000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_LOAD;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_LOAD:  if (start && last_edge) state_next = S_INIT;
      S_INIT:  if (sts.init_done) state_next = S_SCAN;
      S_SCAN:  if (sts.scan_done) state_next = sts.found ? S_LOOK : S_EMIT;
      S_LOOK:  state_next = S_CMP;
      S_CMP:   state_next = sts.take ? S_MERGE : S_SCAN;
      S_MERGE: if (sts.merge_done) state_next = S_SCAN;
      S_EMIT:  if (sts.emit_done) state_next = S_LOAD;
      default: state_next = S_LOAD;
    endcase
  end

  assign busy      = (state != S_LOAD);
  assign cmd.store = (state == S_LOAD) && start;
  assign cmd.init  = (state == S_INIT);
  assign cmd.scan  = (state == S_SCAN);
  assign cmd.look  = (state == S_LOOK);
  assign cmd.cmp   = (state == S_CMP);
  assign cmd.merge = (state == S_MERGE);
  assign cmd.emit  = (state == S_EMIT);
endmodule

// File: rtl/mstk_dpath.sv
// Edge store, min-key scan, component labels, tree store and result register.
`timescale 1ns / 1ps
module mstk_dpath (
  input  logic                                   clk,
  input  logic                                   rst,
  input  mstk_pkg::cmd_t                         cmd,
  output mstk_pkg::sts_t                         sts,
  input  logic                                   cfg_valid,
  input  logic [mstk_pkg::CFGW-1:0]              cfg_data,
  input  logic [mstk_pkg::VW-1:0]                edge_src,
  input  logic [mstk_pkg::VW-1:0]                edge_dest,
  input  logic signed [mstk_pkg::WEIGHT_BITS-1:0] edge_weight,
  output logic                                   result_strobe,
  output logic [mstk_pkg::VW-1:0]                tree_src,
  output logic [mstk_pkg::VW-1:0]                tree_dest,
  output logic signed [mstk_pkg::WEIGHT_BITS-1:0] tree_weight,
  output logic                                   tree_valid,
  output logic                                   last_result,
  output logic                                   edges_dropped
);
  localparam int VW   = mstk_pkg::VW;
  localparam int CFGW = mstk_pkg::CFGW;
  localparam int EW   = mstk_pkg::EW;
  localparam int CW   = mstk_pkg::CW;
  localparam int KW   = mstk_pkg::KW;
  localparam int WB   = mstk_pkg::WEIGHT_BITS;
  localparam logic [CW-1:0]   EDGE_CAP = CW'(mstk_pkg::MAX_EDGES);
  localparam logic [CFGW-1:0] NV_MAX   = CFGW'(mstk_pkg::MAX_VERTICES);
  localparam logic [VW-1:0]   V_LAST   = VW'(mstk_pkg::MAX_VERTICES - 1);
  localparam logic [VW-1:0]   TREE_CAP = VW'(mstk_pkg::MAX_VERTICES - 1);

  mstk_pkg::edge_t edge_mem [mstk_pkg::MAX_EDGES];
  logic [VW-1:0]   label_mem [mstk_pkg::MAX_VERTICES];
  mstk_pkg::edge_t tree_mem [mstk_pkg::MAX_VERTICES];

  logic [CFGW-1:0] vertex_count;
  logic [CW-1:0]   edge_count;
  logic            overflow_seen;

  // scan pipeline
  logic [CW-1:0]   rd_idx;
  logic            rd_vld;
  logic [EW-1:0]   rd_tag;
  mstk_pkg::edge_t rd_edge;
  logic            best_vld;
  logic [KW-1:0]   best_key;
  mstk_pkg::edge_t best_edge;
  logic            have_prev;
  logic [KW-1:0]   prev_key;
  logic [KW-1:0]   cand_key;
  logic            cand_ok;

  // union-find labels
  logic [VW-1:0]   init_idx;
  logic [VW-1:0]   la, lb;
  logic [VW-1:0]   lab_addr;
  logic [CFGW-1:0] mg_idx;
  logic            mg_vld;
  logic [VW-1:0]   mg_tag;
  logic [VW-1:0]   mg_lab;
  logic [VW-1:0]   tree_count;
  logic [CFGW-1:0] nv;
  logic            in_rng;

  // emit
  logic [CFGW-1:0] em_idx;
  logic [CFGW-1:0] em_end;
  logic            tree_empty;

  always_ff @(posedge clk) begin
    if (rst) vertex_count <= NV_MAX;
    else if (cfg_valid) vertex_count <= cfg_data;
  end

  // load
  always_ff @(posedge clk) begin
    if (cmd.store && edge_count != EDGE_CAP)
      edge_mem[edge_count[EW-1:0]] <= '{src: edge_src, dest: edge_dest, weight: edge_weight};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      edge_count    <= '0;
      overflow_seen <= 1'b0;
    end else if (cmd.emit && sts.emit_done) begin
      edge_count    <= '0;
      overflow_seen <= 1'b0;
    end else if (cmd.store) begin
      if (edge_count != EDGE_CAP) edge_count <= edge_count + CW'(1);
      else overflow_seen <= 1'b1;
    end
  end

  // scan: find the smallest {weight, index} above the last one picked
  always_ff @(posedge clk) begin
    rd_edge <= edge_mem[rd_idx[EW-1:0]];
    rd_tag  <= rd_idx[EW-1:0];
  end

  assign cand_key = {~rd_edge.weight[WB-1], rd_edge.weight[WB-2:0], rd_tag};
  assign cand_ok  = rd_vld && (!have_prev || cand_key > prev_key)
                    && (!best_vld || cand_key < best_key);

  always_ff @(posedge clk) begin
    if (rst || !cmd.scan) begin
      rd_idx <= '0;
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= (rd_idx != edge_count);
      if (rd_idx != edge_count) rd_idx <= rd_idx + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.init || cmd.cmp) best_vld <= 1'b0;
    else if (cmd.scan && cand_ok) best_vld <= 1'b1;
  end

  always_ff @(posedge clk) begin
    if (cmd.scan && cand_ok) begin
      best_key  <= cand_key;
      best_edge <= rd_edge;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.init) have_prev <= 1'b0;
    else if (cmd.cmp) have_prev <= 1'b1;
  end

  always_ff @(posedge clk) begin
    if (cmd.cmp) prev_key <= best_key;
  end

  // labels: init writes v, merge relabels la to lb
  always_ff @(posedge clk) begin
    if (cmd.init) label_mem[init_idx] <= init_idx;
    else if (cmd.merge && mg_vld && mg_lab == la) label_mem[mg_tag] <= lb;
  end

  always_ff @(posedge clk) begin
    if (rst || !cmd.init) init_idx <= '0;
    else init_idx <= init_idx + VW'(1);
  end

  // two read ports: src lookup shares one with the relabel sweep
  assign lab_addr = cmd.look ? best_edge.src : mg_idx[VW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.look) begin
      la <= label_mem[lab_addr];
      lb <= label_mem[best_edge.dest];
    end
    mg_lab <= label_mem[lab_addr];
    mg_tag <= mg_idx[VW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst || !cmd.merge) begin
      mg_idx <= '0;
      mg_vld <= 1'b0;
    end else begin
      mg_vld <= (mg_idx != NV_MAX);
      if (mg_idx != NV_MAX) mg_idx <= mg_idx + CFGW'(1);
    end
  end

  assign nv     = (vertex_count > NV_MAX) ? NV_MAX : vertex_count;
  assign in_rng = ({1'b0, best_edge.src} < nv) && ({1'b0, best_edge.dest} < nv);

  always_ff @(posedge clk) begin
    if (rst || cmd.init) tree_count <= '0;
    else if (cmd.cmp && sts.take) tree_count <= tree_count + VW'(1);
  end

  always_ff @(posedge clk) begin
    if (cmd.cmp && sts.take) tree_mem[tree_count] <= best_edge;
  end

  // emit
  assign tree_empty = (tree_count == '0);
  assign em_end     = tree_empty ? CFGW'(1) : {1'b0, tree_count};

  always_ff @(posedge clk) begin
    if (rst || !cmd.emit) em_idx <= '0;
    else if (em_idx != em_end) em_idx <= em_idx + CFGW'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) result_strobe <= 1'b0;
    else result_strobe <= cmd.emit && (em_idx != em_end);
  end

  always_ff @(posedge clk) begin
    tree_src      <= tree_empty ? '0 : tree_mem[em_idx[VW-1:0]].src;
    tree_dest     <= tree_empty ? '0 : tree_mem[em_idx[VW-1:0]].dest;
    tree_weight   <= tree_empty ? '0 : tree_mem[em_idx[VW-1:0]].weight;
    tree_valid    <= !tree_empty;
    last_result   <= (em_idx == em_end - CFGW'(1));
    edges_dropped <= overflow_seen;
  end

  assign sts.init_done  = cmd.init && (init_idx == V_LAST);
  assign sts.scan_done  = (rd_idx == edge_count) && !rd_vld;
  assign sts.found      = best_vld;
  assign sts.take       = in_rng && (la != lb) && (tree_count != TREE_CAP);
  assign sts.merge_done = (mg_idx == NV_MAX) && !mg_vld;
  assign sts.emit_done  = (em_idx == em_end);
endmodule

// File: rtl/minimum_spanning_tree_kruskal.sv
// Top level of the Kruskal minimum spanning forest block.
`timescale 1ns / 1ps
// Edges load one per cycle: an edge request is taken when start is high and
// busy is low. The edge with last_edge set closes the graph and busy rises.
// The block then clears its component labels, and for every edge picked in
// ascending {weight, arrival} order it scans the edge store, looks up both
// endpoint labels and, when the edge joins two components, relabels all 64
// vertices. A last scan finds nothing left. Results then come out one per
// cycle on result_strobe, each for exactly one cycle; the receiver cannot
// stall them. The last tree edge carries last_result; a graph with no tree
// edge gives one result with tree_valid low. Edges past 256 are dropped and
// edges_dropped reports it. Edges with an endpoint at or above vertex_count
// are skipped. vertex_count (reset 64) is written through cfg_valid/cfg_data;
// cfg_ready follows !busy, so a write never lands mid-graph processing.
module minimum_spanning_tree_kruskal (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  output logic                                   busy,
  input  logic [mstk_pkg::VW-1:0]                edge_src,
  input  logic [mstk_pkg::VW-1:0]                edge_dest,
  input  logic signed [mstk_pkg::WEIGHT_BITS-1:0] edge_weight,
  input  logic                                   last_edge,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [mstk_pkg::CFGW-1:0]              cfg_data,
  output logic                                   result_strobe,
  output logic [mstk_pkg::VW-1:0]                tree_src,
  output logic [mstk_pkg::VW-1:0]                tree_dest,
  output logic signed [mstk_pkg::WEIGHT_BITS-1:0] tree_weight,
  output logic                                   tree_valid,
  output logic                                   last_result,
  output logic                                   edges_dropped
);
  mstk_pkg::cmd_t cmd;
  mstk_pkg::sts_t sts;

  assign cfg_ready = !busy;

  mstk_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .last_edge (last_edge),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy)
  );

  mstk_dpath u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .cfg_valid     (cfg_valid && cfg_ready),
    .cfg_data      (cfg_data),
    .edge_src      (edge_src),
    .edge_dest     (edge_dest),
    .edge_weight   (edge_weight),
    .result_strobe (result_strobe),
    .tree_src      (tree_src),
    .tree_dest     (tree_dest),
    .tree_weight   (tree_weight),
    .tree_valid    (tree_valid),
    .last_result   (last_result),
    .edges_dropped (edges_dropped)
  );
endmodule

// File: rtl/mstk_checker.sv
// Port-level checks for the spanning tree block, bound to the top level.
`timescale 1ns / 1ps
`include "minimum_spanning_tree_kruskal_defines.svh"
module mstk_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic last_edge,
  input logic result_strobe,
  input logic tree_valid,
  input logic last_result
);
  `MSTK_CHK_NOW(a_empty_is_last, result_strobe && !tree_valid, last_result)
  `MSTK_CHK_NOW(a_result_while_busy, result_strobe, busy)
  `MSTK_CHK_NEXT(a_quiet_after_last, result_strobe && last_result, !result_strobe)
  `MSTK_CHK_NEXT(a_load_stays_idle, start && !busy && !last_edge, !busy)
  `MSTK_CHK_NEXT(a_last_goes_busy, start && !busy && last_edge, busy)
endmodule

bind minimum_spanning_tree_kruskal mstk_checker u_mstk_checker (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .last_edge     (last_edge),
  .result_strobe (result_strobe),
  .tree_valid    (tree_valid),
  .last_result   (last_result)
);

// File: sim/minimum_spanning_tree_kruskal_test.sv
// Testbench for the Kruskal minimum spanning forest block: directed and random graphs.
`timescale 1ns / 1ps
module minimum_spanning_tree_kruskal_test;
  localparam int VW           = mstk_pkg::VW;
  localparam int CFGW         = mstk_pkg::CFGW;
  localparam int WEIGHT_BITS  = mstk_pkg::WEIGHT_BITS;
  localparam int MAX_VERTICES = mstk_pkg::MAX_VERTICES;
  localparam int MAX_EDGES    = mstk_pkg::MAX_EDGES;

  // The watchdog allows for a full graph that fills the edge store.
  localparam int STALL_LIMIT = 300000;
  localparam int SETTLE = 20;

  // One expected tree-edge request as it appears on the result ports.
  typedef struct {
    logic [VW-1:0]                 src;
    logic [VW-1:0]                 dest;
    logic signed [WEIGHT_BITS-1:0] weight;
    logic                          valid;
    logic                          last;
    logic                          dropped;
  } tree_edge_t;

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  logic busy;
  logic [VW-1:0] edge_src = '0;
  logic [VW-1:0] edge_dest = '0;
  logic signed [WEIGHT_BITS-1:0] edge_weight = '0;
  logic last_edge = 0;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [CFGW-1:0] cfg_data = '0;
  logic result_strobe;
  logic [VW-1:0] tree_src, tree_dest;
  logic signed [WEIGHT_BITS-1:0] tree_weight;
  logic tree_valid, last_result, edges_dropped;

  minimum_spanning_tree_kruskal DUT (.*);

  always #2 clk = ~clk;

  // Predictor state: edges of the graph being loaded, vertex count, forest.
  mstk_pkg::edge_t graph_edges[$];
  bit              graph_overflow;
  int              vertex_limit = 64;
  int              forest_parent[MAX_VERTICES];
  int              forest_rank[MAX_VERTICES];
  tree_edge_t      tree_expect[$];
  int              errors = 0;
  int              idle_cycles = 0;
  bit              no_gaps = 0;

  function automatic int root_of(int x);
    int r;
    int n;
    r = x;
    while (forest_parent[r] != r) r = forest_parent[r];
    while (x != r) begin
      n = forest_parent[x];
      forest_parent[x] = r;
      x = n;
    end
    return r;
  endfunction

  // Kruskal on the stored graph: stable sort by weight, then union-find.
  function automatic void build_forest();
    mstk_pkg::edge_t sorted[$];
    mstk_pkg::edge_t key;
    tree_edge_t t;
    int j, ra, rb, nv, found;
    sorted = graph_edges;
    for (int i = 1; i < sorted.size(); i++) begin
      key = sorted[i];
      j = i;
      while (j > 0 && sorted[j-1].weight > key.weight) begin
        sorted[j] = sorted[j-1];
        j--;
      end
      sorted[j] = key;
    end
    nv = (vertex_limit > MAX_VERTICES) ? MAX_VERTICES : vertex_limit;
    for (int v = 0; v < MAX_VERTICES; v++) begin
      forest_parent[v] = v;
      forest_rank[v] = 0;
    end
    found = 0;
    foreach (sorted[i]) begin
      if (sorted[i].src >= nv || sorted[i].dest >= nv) continue;
      ra = root_of(sorted[i].src);
      rb = root_of(sorted[i].dest);
      if (ra == rb || found >= MAX_VERTICES - 1) continue;
      if (forest_rank[ra] < forest_rank[rb]) forest_parent[ra] = rb;
      else if (forest_rank[ra] > forest_rank[rb]) forest_parent[rb] = ra;
      else begin
        forest_parent[ra] = rb;
        if (forest_rank[rb] < 7) forest_rank[rb]++;
      end
      t.src = sorted[i].src;
      t.dest = sorted[i].dest;
      t.weight = sorted[i].weight;
      t.valid = 1;
      t.last = 0;
      t.dropped = graph_overflow;
      tree_expect = {tree_expect, t};
      found++;
    end
    if (found == 0) begin
      t.src = '0;
      t.dest = '0;
      t.weight = '0;
      t.valid = 0;
      t.last = 1;
      t.dropped = graph_overflow;
      tree_expect = {tree_expect, t};
    end else begin
      tree_expect[tree_expect.size()-1].last = 1;
    end
    graph_edges.delete();
    graph_overflow = 0;
  endfunction

  // Send one edge request; gap drawn per item unless bursting.
  task automatic send_edge(int s, int d, int w, bit last);
    int gap;
    mstk_pkg::edge_t e;
    gap = no_gaps ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      start <= 0;
      repeat (gap) @(posedge clk);
    end
    start <= 1;
    edge_src <= s[VW-1:0];
    edge_dest <= d[VW-1:0];
    edge_weight <= w[WEIGHT_BITS-1:0];
    last_edge <= last;
    do @(posedge clk); while (busy);
    e.src = s[VW-1:0];
    e.dest = d[VW-1:0];
    e.weight = w[WEIGHT_BITS-1:0];
    if (graph_edges.size() < MAX_EDGES) graph_edges = {graph_edges, e};
    else graph_overflow = 1;
    if (last) build_forest();
  endtask

  // Sender holds off until every expected result has come, then settles.
  task automatic drain();
    start <= 0;
    while (tree_expect.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_vertex_count(int v);
    cfg_valid <= 1;
    cfg_data <= v[CFGW-1:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    vertex_limit = v & 'h7f;
  endtask

  // Result checker: every strobe must match the oldest expectation.
  always @(posedge clk) begin
    if (!rst && result_strobe) begin
      if (tree_expect.size() == 0) begin
        $error("unexpected result request");
        errors++;
      end else begin
        tree_edge_t x;
        x = tree_expect.pop_front();
        if (tree_src !== x.src) begin
          $error("tree_src exp %0d got %0d", x.src, tree_src); errors++;
        end
        if (tree_dest !== x.dest) begin
          $error("tree_dest exp %0d got %0d", x.dest, tree_dest); errors++;
        end
        if (tree_weight !== x.weight) begin
          $error("tree_weight exp %0d got %0d", x.weight, tree_weight); errors++;
        end
        if (tree_valid !== x.valid) begin
          $error("tree_valid exp %0d got %0d", x.valid, tree_valid); errors++;
        end
        if (last_result !== x.last) begin
          $error("last_result exp %0d got %0d", x.last, last_result); errors++;
        end
        if (edges_dropped !== x.dropped) begin
          $error("edges_dropped exp %0d got %0d", x.dropped, edges_dropped); errors++;
        end
      end
    end
  end

  // Watchdog: counts cycles in which no request of any kind moves.
  always @(posedge clk) begin
    if (rst || (start && !busy) || result_strobe || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Single edges, self loop, extreme weights and vertices, weight ties.
  task automatic test_directed();
    send_edge(0, 63, -32768, 1);
    send_edge(5, 5, 100, 1);
    send_edge(63, 0, 32767, 0);
    send_edge(1, 2, 7, 0);
    send_edge(2, 3, 7, 0);
    send_edge(1, 3, 7, 0);
    send_edge(0, 63, -32768, 0);
    send_edge(3, 3, -1, 0);
    send_edge(42, 21, 0, 1);
    drain();
  endtask

  // Vertex count extremes, including zero and above the maximum.
  task automatic test_vertex_count();
    write_vertex_count(1);
    send_edge(0, 0, 3, 0);
    send_edge(0, 1, 4, 1);
    drain();
    write_vertex_count(2);
    send_edge(0, 1, 9, 0);
    send_edge(1, 2, 1, 0);
    send_edge(1, 0, -9, 1);
    drain();
    write_vertex_count(0);
    send_edge(0, 1, 5, 1);
    drain();
    write_vertex_count(127);
    send_edge(62, 63, 5, 0);
    send_edge(0, 63, 5, 1);
    drain();
    write_vertex_count(64);
  endtask

  // Random graphs over several vertex counts; mostly in-range endpoints.
  task automatic test_random_graphs();
    int sent, n, vc, hi, s, d, w;
    sent = 0;
    while (sent < 150) begin
      case ($urandom_range(0, 4))
        0: vc = 64;
        1: vc = 2;
        2: vc = 8;
        default: vc = $urandom_range(1, 64);
      endcase
      write_vertex_count(vc);
      no_gaps = ($urandom_range(0, 3) == 0);
      n = $urandom_range(1, 12);
      for (int i = 0; i < n; i++) begin
        hi = (vc > 64) ? 63 : vc - 1;
        if ($urandom_range(0, 9) == 0) begin
          s = $urandom_range(0, 63);
          d = $urandom_range(0, 63);
        end else begin
          s = $urandom_range(0, hi);
          d = $urandom_range(0, hi);
        end
        w = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 65535)
                                         : $urandom_range(0, 4) - 2;
        send_edge(s, d, w, i == n - 1);
      end
      sent += n;
      no_gaps = 0;
      drain();
    end
  endtask

  initial begin
    graph_overflow = 0;
    repeat (2) @(posedge clk);
    rst <= 0;
    test_directed();
    test_vertex_count();
    test_random_graphs();
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end
endmodule
